>>> hw/rtl/esd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // Saturation point of the decoded length
  localparam int MAX_LENGTH = 2048;
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int LEN_W      = 12;

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_X      = 8'h78;

  // Decoded control bytes
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_BS  = 8'd8;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ESC  = 2'd1;
  localparam logic [1:0] ERR_HEX  = 2'd2;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_ESC,
    PH_HEX1,
    PH_HEX2,
    PH_DROP
  } esd_phase_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } esd_in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [1:0]       error_kind;
    logic             done_res;
    logic [LEN_W-1:0] decoded_length;
  } esd_out_t;

  typedef struct packed {
    esd_phase_t       phase;
    logic [3:0]       high_nibble;
    logic [CNT_W-1:0] count;
  } esd_state_t;

  localparam esd_state_t ST_RESET = '{phase: PH_NORMAL, high_nibble: 4'd0, count: '0};

  // {ok, nibble}; ok is 0 for a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/esd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-character decode: one word plus current state in, optional result
// and next state out. Purely combinational.
module esd_decode
  import esd_pkg::*;
(
  input  wire esd_in_t    item,
  input  wire esd_state_t st,
  output logic            res_valid,
  output esd_out_t        res,
  output esd_state_t      st_nxt
);

  logic [7:0]       c;
  logic             last;
  logic [4:0]       hx;
  logic             emit_en;
  logic [7:0]       emit_val;
  logic             err_en;
  logic [1:0]       err_kind;
  logic [CNT_W-1:0] cnt_inc;

  assign c       = item.in_char;
  assign last    = item.is_last;
  assign hx      = hex_value(c);
  assign cnt_inc = (st.count < CNT_W'(MAX_LENGTH)) ? st.count + 1'b1 : st.count;

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    st_nxt    = st;
    emit_en   = 1'b0;
    emit_val  = 8'd0;
    err_en    = 1'b0;
    err_kind  = ERR_NONE;

    if (st.phase == PH_DROP) begin
      if (last) st_nxt = ST_RESET;
    end else if (c == CH_NUL) begin
      if (last && st.phase == PH_NORMAL) begin
        // empty end marker
        res_valid          = 1'b1;
        res.done_res       = 1'b1;
        res.decoded_length = LEN_W'(st.count);
        st_nxt             = ST_RESET;
      end else begin
        err_en   = 1'b1;
        err_kind = ERR_ESC;
      end
    end else begin
      unique case (st.phase)
        PH_NORMAL: begin
          if (c == CH_BSLASH) begin
            if (last) begin
              err_en   = 1'b1;
              err_kind = ERR_ESC;
            end else begin
              st_nxt.phase = PH_ESC;
            end
          end else begin
            emit_en  = 1'b1;
            emit_val = c;
          end
        end
        PH_ESC: begin
          if (c == CH_N) begin
            emit_en  = 1'b1;
            emit_val = BYTE_LF;
          end else if (c == CH_R) begin
            emit_en  = 1'b1;
            emit_val = BYTE_CR;
          end else if (c == CH_T) begin
            emit_en  = 1'b1;
            emit_val = BYTE_TAB;
          end else if (c == CH_B) begin
            emit_en  = 1'b1;
            emit_val = BYTE_BS;
          end else if (c == CH_X && !last) begin
            st_nxt.phase = PH_HEX1;
          end else begin
            err_en   = 1'b1;
            err_kind = ERR_ESC;
          end
        end
        PH_HEX1: begin
          if (!hx[4]) begin
            err_en   = 1'b1;
            err_kind = ERR_HEX;
          end else if (last) begin
            err_en   = 1'b1;
            err_kind = ERR_ESC;
          end else begin
            st_nxt.high_nibble = hx[3:0];
            st_nxt.phase       = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hx[4]) begin
            err_en   = 1'b1;
            err_kind = ERR_HEX;
          end else begin
            emit_en  = 1'b1;
            emit_val = {st.high_nibble, hx[3:0]};
          end
        end
        default: st_nxt = ST_RESET;
      endcase
    end

    if (emit_en) begin
      res_valid          = 1'b1;
      res.out_byte       = emit_val;
      res.byte_valid     = 1'b1;
      res.done_res       = last;
      res.decoded_length = LEN_W'(cnt_inc);
      if (last) begin
        st_nxt = ST_RESET;
      end else begin
        st_nxt.phase = PH_NORMAL;
        st_nxt.count = cnt_inc;
      end
    end

    if (err_en) begin
      // length reported is the count before the failing escape
      res_valid          = 1'b1;
      res.error_kind     = err_kind;
      res.done_res       = 1'b1;
      res.decoded_length = LEN_W'(st.count);
      if (last) st_nxt = ST_RESET;
      else      st_nxt.phase = PH_DROP;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/escape_sequence_decoder.sv
// Backslash escape decoder for a character string.
// Input channel (in_valid/in_ready/in_data): one character word per
// transfer, with is_last on the final word of a string. A zero character
// is only legal as an empty last word (end marker).
// Result channel (out_valid/out_ready/out_data): at most one word per input
// word. Plain characters and \n \r \t \b \xHH give a decoded byte; the last
// word of a string carries done_res and the decoded length (saturating).
// A malformed escape gives an error word with done_res set; later input
// words up to and including the next last-marked one give no result.
// Escape introducers (\ and \x and the first hex digit) give no result.
// Path: a word is captured in the input register, decoded while it sits
// there, and its result is then registered in the output register, which
// drives out_valid. Throughput: one word per cycle while the output is not
// stalled; the phase/nibble/count state is updated in the same cycle the
// word is decoded, which is what bounds the rate.
// Reset (rst_n low, synchronous): both registers empty, decoder back in
// normal text with a zero length.
// Receiver stall: the output register holds its word; the input register
// still drains words that produce no result, and in_ready drops once a
// word with a result is waiting behind the held output.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  wire esd_in_t  in_data,
  output logic          out_valid,
  input  wire           out_ready,
  output esd_out_t      out_data
);

  logic       s1_valid_r;
  esd_in_t    s1_data_r;
  esd_state_t st_r;
  esd_state_t st_nxt;
  logic       out_valid_r;
  esd_out_t   out_data_r;

  logic       res_valid;
  esd_out_t   res;
  logic       out_free;
  logic       s1_adv;

  esd_decode u_decode (
    .item      (s1_data_r),
    .st        (st_r),
    .res_valid (res_valid),
    .res       (res),
    .st_nxt    (st_nxt)
  );

  // the held word leaves the input register when its result has a slot,
  // or when it makes no result at all
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (out_free || !res_valid);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_RESET;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) st_r <= st_nxt;
      if (s1_adv && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (s1_adv && res_valid) out_data_r <= res;
  end

endmodule

`default_nettype wire

>>> hw/rtl/esd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_checker
  import esd_pkg::*;
(
  input wire           clk,
  input wire           rst_n,
  input wire           in_valid,
  input wire           in_ready,
  input wire esd_in_t  in_data,
  input wire           out_valid,
  input wire           out_ready,
  input wire esd_out_t out_data
);

  // input word holds while waiting
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // error words close the string and carry no byte
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_kind != ERR_NONE |->
      out_data.done_res && !out_data.byte_valid)
    else $error("error word without done or with a byte");

  // a decoded byte always counts itself
  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |->
      out_data.decoded_length != 0 && out_data.decoded_length <= MAX_LENGTH)
    else $error("decoded length out of range on a byte word");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
